/* src/epp_pkg.sv */
// Shared constants for the equidistant fisheye projection pipeline.
// Holds data widths, configuration register indexes and the CORDIC arctangent table.
package epp_pkg;

  localparam int DATA_W           = 32;
  localparam int ANG_BITS         = 30;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ISQ_STEPS        = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int ZW               = 33;   // CORDIC angle accumulator, signed Q30
  localparam int CW               = 64;   // CORDIC x/y datapath

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMOG    = 3'd4;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  // floor(atan(2^-i) * 2^30)
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd7,         30'd3,         30'd1,
    30'd0,         30'd0
  };

endpackage

/* src/epp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes on one divisor.
// Depends on epp_pkg.
module epp_div import epp_pkg::*; #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W][LANES];
  logic [NUM_W-1:0]  num_q  [NUM_W][LANES];
  logic [NUM_W-1:0]  quo_q  [NUM_W][LANES];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W-1:0]  rem_in [LANES];
    logic [NUM_W-1:0]  num_in [LANES];
    logic [NUM_W-1:0]  quo_in [LANES];
    logic [DEN_W-1:0]  rem_d  [LANES];
    logic [NUM_W-1:0]  num_d  [LANES];
    logic [NUM_W-1:0]  quo_d  [LANES];

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = '0;
        assign num_in[l] = num_i[l];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l];
        assign num_in[l] = num_q[k-1][l];
        assign quo_in[l] = quo_q[k-1][l];
      end
    end

    always_comb begin
      logic [DEN_W:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_in[l], num_in[l][NUM_W-1]};
        if (trial >= {1'b0, den_in}) begin
          rem_d[l] = DEN_W'(trial - {1'b0, den_in});
          quo_d[l] = {quo_in[l][NUM_W-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[DEN_W-1:0];
          quo_d[l] = {quo_in[l][NUM_W-2:0], 1'b0};
        end
        num_d[l] = num_in[l] << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[l];
          num_q[k][l] <= num_d[l];
          quo_q[k][l] <= quo_d[l];
        end
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = quo_q[NUM_W-1][l];
  end

endmodule

/* src/epp_isqrt.sv */
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on epp_pkg.
module epp_isqrt import epp_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [ISQ_STEPS];
  logic [63:0]       n_q    [ISQ_STEPS];
  logic [63:0]       res_q  [ISQ_STEPS];
  logic [SIDE_W-1:0] side_q [ISQ_STEPS];

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic              v_in;
    logic [63:0]       n_in;
    logic [63:0]       res_in;
    logic [SIDE_W-1:0] side_in;
    logic [63:0]       n_d;
    logic [63:0]       res_d;
    logic [64:0]       trial;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign n_in    = n_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    always_comb begin
      if ({1'b0, n_in} >= trial) begin
        n_d   = n_in - trial[63:0];
        res_d = (res_in >> 1) + BIT;
      end else begin
        n_d   = n_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ISQ_STEPS-1];
  assign root_o  = res_q[ISQ_STEPS-1][31:0];
  assign side_o  = side_q[ISQ_STEPS-1];

endmodule

/* src/epp_cordic.sv */
// Pipelined vectoring CORDIC giving atan of a QF radius as a Q30 angle.
// Depends on epp_pkg for the arctangent table and datapath widths.
module epp_cordic import epp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int STEPS     = CORDIC_STEPS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [31:0]          radius_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic signed [ZW-1:0] angle_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic                 vld_q  [STEPS];
  logic signed [CW-1:0] x_q    [STEPS];
  logic signed [CW-1:0] y_q    [STEPS];
  logic signed [ZW-1:0] z_q    [STEPS];
  logic [SIDE_W-1:0]    side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic                 v_in;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic [SIDE_W-1:0]    side_in;
    logic signed [CW-1:0] x_d;
    logic signed [CW-1:0] y_d;
    logic signed [ZW-1:0] z_d;
    logic signed [ZW-1:0] step_ang;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = CW'(64'd1 << ANG_BITS);
      assign y_in    = $signed(CW'(radius_i) << (ANG_BITS - FRAC_BITS));
      assign z_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign step_ang = $signed({3'b000, ATAN_TAB[k]});

    // rotate toward the x axis
    always_comb begin
      if (!y_in[CW-1]) begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        z_d = z_in + step_ang;
      end else begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        z_d = z_in - step_ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign angle_o = z_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

/* src/equidistant_point_projection.sv */
// Top level of the equidistant fisheye projection pipeline with output skid stage.
// Depends on epp_pkg, epp_div, epp_isqrt and epp_cordic.
//
// Usage:
//   Input channel in_valid_i/in_stall_o carries one scene point (X, Y, Z) per
//   transaction; output channel out_valid_o/out_stall_i returns one image point
//   (x, y, w) and a status bit per transaction, in order.
//   Configuration (focal lengths, centre, homogeneous scale) is written through
//   cfg_we_i/cfg_idx_i/cfg_data_i while no transaction is in flight.
//   Most of the pipeline is the two bit-per-stage dividers, the 32-stage square
//   root and the CORDIC stages. Throughput is one transaction per cycle while
//   the skid register is empty.
//   A zero Z gives status 1 and zero image fields.
//   Reset empties the pipeline and loads focal 1.0, centre 0 and scale 1.0.
//   When the receiver stalls, the result waits in the output register and the
//   pipeline keeps running until one more result fills the skid register;
//   in_stall_o then rises until the output drains.
module equidistant_point_projection import epp_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] scene_x_i,
  input  logic signed [DATA_W-1:0] scene_y_i,
  input  logic signed [DATA_W-1:0] scene_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] image_x_o,
  output logic signed [DATA_W-1:0] image_y_o,
  output logic signed [DATA_W-1:0] image_w_o,
  output logic                     status_o
);

  localparam int QW    = DATA_W + FRAC_BITS;  // divider quotient width
  localparam int DW    = 34;                  // signed Q30 factor
  localparam int MW    = DW + DATA_W;
  localparam int SW    = MW - ANG_BITS;
  localparam int PXW   = SW + DATA_W;
  localparam int PW    = PXW - FRAC_BITS;
  localparam int PSW   = PW + 1;
  localparam int ISQ_SW = 2 * DATA_W + 2;
  localparam int COR_SW = ISQ_SW + DATA_W;
  localparam int DV2_SW = ISQ_SW + 1;
  localparam logic [63:0] SMALL_THR = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
  localparam logic [QW-1:0] Q_POS_LIM = QW'(S32_MAX);
  localparam logic [QW-1:0] Q_NEG_LIM = QW'(S32_MIN);

  function automatic logic [DATA_W-1:0] sat_quo(logic [QW-1:0] q, logic neg);
    if (neg) begin
      if (q > Q_NEG_LIM) return S32_MIN;
      return DATA_W'(QW'(0) - q);
    end
    if (q > Q_POS_LIM) return S32_MAX;
    return q[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_out(logic [PSW-1:0] t);
    if (&t[PSW-1:DATA_W-1] || ~|t[PSW-1:DATA_W-1]) return t[DATA_W-1:0];
    return t[PSW-1] ? S32_MIN : S32_MAX;
  endfunction

  // configuration registers
  logic signed [DATA_W-1:0] focal_x_q, focal_y_q, centre_x_q, centre_y_q, homog_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= DATA_W'(64'd1 << FRAC_BITS);
      focal_y_q  <= DATA_W'(64'd1 << FRAC_BITS);
      centre_x_q <= '0;
      centre_y_q <= '0;
      homog_q    <= DATA_W'(64'd1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        CFG_CENTRE_X: centre_x_q <= cfg_data_i;
        CFG_CENTRE_Y: centre_y_q <= cfg_data_i;
        CFG_HOMOG:    homog_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance, held only while the skid register is full
  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 0: magnitudes and signs
  logic              s0_v_q, s0_zero_q, s0_nu_q, s0_nv_q;
  logic [DATA_W-1:0] s0_ax_q, s0_ay_q, s0_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_zero_q <= (scene_z_i == '0);
      s0_nu_q   <= scene_x_i[DATA_W-1] ^ scene_z_i[DATA_W-1];
      s0_nv_q   <= scene_y_i[DATA_W-1] ^ scene_z_i[DATA_W-1];
      s0_ax_q   <= scene_x_i[DATA_W-1] ? DATA_W'(-scene_x_i) : scene_x_i;
      s0_ay_q   <= scene_y_i[DATA_W-1] ? DATA_W'(-scene_y_i) : scene_y_i;
      s0_az_q   <= scene_z_i[DATA_W-1] ? DATA_W'(-scene_z_i) : scene_z_i;
    end
  end

  // u = X/Z and v = Y/Z
  logic [QW-1:0] dv1_num [2];
  logic [QW-1:0] dv1_quo [2];
  logic [2:0]    dv1_side;
  logic          dv1_v;

  assign dv1_num[0] = {s0_ax_q, {FRAC_BITS{1'b0}}};
  assign dv1_num[1] = {s0_ay_q, {FRAC_BITS{1'b0}}};

  epp_div #(.NUM_W(QW), .DEN_W(DATA_W), .LANES(2), .SIDE_W(3)) u_div_uv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_i   (dv1_num),
    .den_i   (s0_az_q),
    .side_i  ({s0_zero_q, s0_nu_q, s0_nv_q}),
    .valid_o (dv1_v),
    .quo_o   (dv1_quo),
    .side_o  (dv1_side)
  );

  // sign and saturate quotients
  logic                     q_v_q, q_zero_q;
  logic signed [DATA_W-1:0] q_u_q, q_v_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
    end else if (en) begin
      q_v_q <= dv1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_zero_q  <= dv1_side[2];
      q_u_q     <= sat_quo(dv1_quo[0], dv1_side[1]);
      q_v_val_q <= sat_quo(dv1_quo[1], dv1_side[0]);
    end
  end

  // squares
  logic                     m1_v_q, m1_zero_q;
  logic signed [DATA_W-1:0] m1_u_q, m1_v_val_q;
  logic signed [63:0]       m1_uu_q, m1_vv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= q_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_zero_q  <= q_zero_q;
      m1_u_q     <= q_u_q;
      m1_v_val_q <= q_v_val_q;
      m1_uu_q    <= q_u_q * q_u_q;
      m1_vv_q    <= q_v_val_q * q_v_val_q;
    end
  end

  // r^2 and small-radius test
  logic                     m2_v_q, m2_zero_q, m2_small_q;
  logic signed [DATA_W-1:0] m2_u_q, m2_v_val_q;
  logic [63:0]              m2_r2_q;
  logic [63:0]              r2_d;

  assign r2_d = $unsigned(m1_uu_q) + $unsigned(m1_vv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_zero_q  <= m1_zero_q;
      m2_u_q     <= m1_u_q;
      m2_v_val_q <= m1_v_val_q;
      m2_r2_q    <= r2_d;
      m2_small_q <= (r2_d <= SMALL_THR);
    end
  end

  // r = isqrt(r^2)
  logic              sq_v;
  logic [31:0]       sq_root;
  logic [ISQ_SW-1:0] sq_side;

  epp_isqrt #(.SIDE_W(ISQ_SW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_v_q),
    .rad_i   (m2_r2_q),
    .side_i  ({m2_u_q, m2_v_val_q, m2_zero_q, m2_small_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // atan(r)
  logic                 co_v;
  logic signed [ZW-1:0] co_ang;
  logic [COR_SW-1:0]    co_side;

  epp_cordic #(.FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(COR_SW)) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_v),
    .radius_i (sq_root),
    .side_i   ({sq_side, sq_root}),
    .valid_o  (co_v),
    .angle_o  (co_ang),
    .side_o   (co_side)
  );

  // d = atan(r) / r
  logic [ZW-1:0]     ang_mag;
  logic [QW-1:0]     dv2_num [1];
  logic [QW-1:0]     dv2_quo [1];
  logic [DV2_SW-1:0] dv2_side;
  logic              dv2_v;

  assign ang_mag    = co_ang[ZW-1] ? ZW'(-co_ang) : co_ang;
  assign dv2_num[0] = {ang_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};

  epp_div #(.NUM_W(QW), .DEN_W(DATA_W), .LANES(1), .SIDE_W(DV2_SW)) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (co_v),
    .num_i   (dv2_num),
    .den_i   (co_side[DATA_W-1:0]),
    .side_i  ({co_side[COR_SW-1:DATA_W], co_ang[ZW-1]}),
    .valid_o (dv2_v),
    .quo_o   (dv2_quo),
    .side_o  (dv2_side)
  );

  // factor select
  logic                     d_v_q, d_zero_q;
  logic signed [DATA_W-1:0] d_u_q, d_v_val_q;
  logic signed [DW-1:0]     d_fac_q;
  logic [DW-1:0]            fac_mag;

  assign fac_mag = DW'(dv2_quo[0][DW-2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= dv2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_u_q     <= dv2_side[DV2_SW-1 -: DATA_W];
      d_v_val_q <= dv2_side[DV2_SW-1-DATA_W -: DATA_W];
      d_zero_q  <= dv2_side[2];
      if (dv2_side[1]) begin
        d_fac_q <= DW'(64'd1 << ANG_BITS);
      end else if (dv2_side[0]) begin
        d_fac_q <= DW'(-fac_mag);
      end else begin
        d_fac_q <= fac_mag;
      end
    end
  end

  // d * focal
  logic                     p1_v_q, p1_zero_q;
  logic signed [DATA_W-1:0] p1_u_q, p1_v_val_q;
  logic signed [MW-1:0]     p1_mx_q, p1_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_zero_q  <= d_zero_q;
      p1_u_q     <= d_u_q;
      p1_v_val_q <= d_v_val_q;
      p1_mx_q    <= d_fac_q * focal_x_q;
      p1_my_q    <= d_fac_q * focal_y_q;
    end
  end

  // round to s
  logic                     p2_v_q, p2_zero_q;
  logic signed [DATA_W-1:0] p2_u_q, p2_v_val_q;
  logic signed [SW-1:0]     p2_sx_q, p2_sy_q;
  logic [MW-1:0]            rnd_mx, rnd_my;

  assign rnd_mx = p1_mx_q + (MW'(1) << (ANG_BITS - 1));
  assign rnd_my = p1_my_q + (MW'(1) << (ANG_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_zero_q  <= p1_zero_q;
      p2_u_q     <= p1_u_q;
      p2_v_val_q <= p1_v_val_q;
      p2_sx_q    <= rnd_mx[MW-1:ANG_BITS];
      p2_sy_q    <= rnd_my[MW-1:ANG_BITS];
    end
  end

  // s * u
  logic                  p3_v_q, p3_zero_q;
  logic signed [PXW-1:0] p3_px_q, p3_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_zero_q <= p2_zero_q;
      p3_px_q   <= p2_sx_q * p2_u_q;
      p3_py_q   <= p2_sy_q * p2_v_val_q;
    end
  end

  // round, add centre, saturate
  logic [PXW-1:0]    rnd_px, rnd_py;
  logic [PSW-1:0]    sum_x, sum_y;
  logic [DATA_W-1:0] res_x, res_y, res_w;
  logic              res_st, res_v;

  assign rnd_px = p3_px_q + (PXW'(1) << (FRAC_BITS - 1));
  assign rnd_py = p3_py_q + (PXW'(1) << (FRAC_BITS - 1));
  assign sum_x  = {rnd_px[PXW-1], rnd_px[PXW-1:FRAC_BITS]} + PSW'(centre_x_q);
  assign sum_y  = {rnd_py[PXW-1], rnd_py[PXW-1:FRAC_BITS]} + PSW'(centre_y_q);
  assign res_x  = p3_zero_q ? '0 : sat_out(sum_x);
  assign res_y  = p3_zero_q ? '0 : sat_out(sum_y);
  assign res_w  = p3_zero_q ? '0 : homog_q;
  assign res_st = p3_zero_q;
  assign res_v  = p3_v_q && en;

  // output register and skid register
  logic              out_v_q, out_st_q, skid_st_q;
  logic [DATA_W-1:0] out_x_q, out_y_q, out_w_q, skid_x_q, skid_y_q, skid_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      out_v_q  <= skid_v_q || res_v;
      skid_v_q <= 1'b0;
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_x_q  <= skid_x_q;
        out_y_q  <= skid_y_q;
        out_w_q  <= skid_w_q;
        out_st_q <= skid_st_q;
      end else begin
        out_x_q  <= res_x;
        out_y_q  <= res_y;
        out_w_q  <= res_w;
        out_st_q <= res_st;
      end
    end else if (res_v) begin
      skid_x_q  <= res_x;
      skid_y_q  <= res_y;
      skid_w_q  <= res_w;
      skid_st_q <= res_st;
    end
  end

  assign out_valid_o = out_v_q;
  assign image_x_o   = out_x_q;
  assign image_y_o   = out_y_q;
  assign image_w_o   = out_w_q;
  assign status_o    = out_st_q;

  // a full skid register always sits behind a full output register
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // a frozen pipeline keeps its last stage
  a_hold_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(p3_v_q))
    else $error("pipeline moved while held");

  // a zero-depth result carries zero image fields
  a_zero_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_st_q) |-> (out_x_q == '0 && out_y_q == '0 && out_w_q == '0))
    else $error("zero-depth result with nonzero fields");

  // the skid register only fills from a stalled output
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid register filled without a stall");

endmodule

/* tb/tb_equidistant_point_projection.sv */
// Testbench for equidistant_point_projection: random and directed scene points,
// checked against a fixed-point fisheye projection predictor. Depends on epp_pkg.
`timescale 1ns / 100ps

module tb_equidistant_point_projection;
  import epp_pkg::*;

  localparam int FB       = FRAC_BITS_DEF;
  localparam int STEPS    = CORDIC_STEPS_DEF;
  localparam int LATENCY  = 105 + 2 * FB + STEPS;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic signed [31:0] iw;
    logic               st;
  } image_pt_t;

  class projection_board;
    longint fx, fy, cx, cy, hs;
    image_pt_t pending[$];
    int errors;

    function new();
      fx = 64'sd1 << FB;
      fy = 64'sd1 << FB;
      cx = 0;
      cy = 0;
      hs = 64'sd1 << FB;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic signed [31:0] val);
      case (idx)
        CFG_FOCAL_X:  fx = val;
        CFG_FOCAL_Y:  fy = val;
        CFG_CENTRE_X: cx = val;
        CFG_CENTRE_Y: cy = val;
        CFG_HOMOG:    hs = val;
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint rnd_shift(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function longint isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function longint arctan_q30(longint r);
      longint x, y, z, dx, dy;
      x = 64'sd1 << ANG_BITS;
      y = r <<< (ANG_BITS - FB);
      z = 0;
      for (int i = 0; i < STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
        end
      end
      return z;
    endfunction

    function void note_point(logic signed [31:0] sx, logic signed [31:0] sy,
                             logic signed [31:0] sz);
      longint u, v, d, r, a, s;
      longint unsigned r2, thr;
      image_pt_t e;
      if (sz == 0) begin
        e = '{ix: 0, iy: 0, iw: 0, st: 1'b1};
        pending.push_back(e);
        return;
      end
      u = clip32((longint'(sx) <<< FB) / longint'(sz));
      v = clip32((longint'(sy) <<< FB) / longint'(sz));
      r2 = longint'(u * u) + longint'(v * v);
      thr = (64'd1 << (2 * FB)) / 10000;
      d = 64'sd1 << ANG_BITS;
      if (r2 > thr) begin
        r = isqrt(r2);
        if (r > 0) begin
          a = arctan_q30(r);
          d = (a <<< FB) / r;
        end
      end
      s = rnd_shift(d * fx, ANG_BITS);
      e.ix = 32'(clip32(cx + rnd_shift(s * u, FB)));
      s = rnd_shift(d * fy, ANG_BITS);
      e.iy = 32'(clip32(cy + rnd_shift(s * v, FB)));
      e.iw = 32'(hs);
      e.st = 1'b0;
      pending.push_back(e);
    endfunction

    function void check_point(image_pt_t got);
      image_pt_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d w=%0d st=%0b", $time,
                 got.ix, got.iy, got.iw, got.st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ix !== e.ix) begin
        $display("%0t: image_x expected %0d actual %0d", $time, e.ix, got.ix);
        errors++;
      end
      if (got.iy !== e.iy) begin
        $display("%0t: image_y expected %0d actual %0d", $time, e.iy, got.iy);
        errors++;
      end
      if (got.iw !== e.iw) begin
        $display("%0t: image_w expected %0d actual %0d", $time, e.iw, got.iw);
        errors++;
      end
      if (got.st !== e.st) begin
        $display("%0t: status expected %0b actual %0b", $time, e.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DATA_W-1:0] scene_x_i = '0, scene_y_i = '0, scene_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] image_x_o, image_y_o, image_w_o;
  logic status_o;

  projection_board board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int wdog = 0;
  bit timed_out = 1'b0;

  always #2 clk_i = ~clk_i;

  equidistant_point_projection u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .scene_x_i, .scene_y_i, .scene_z_i,
    .out_valid_o, .out_stall_i, .image_x_o, .image_y_o, .image_w_o, .status_o
  );

  // Check results and randomize stall on the receive side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_point('{ix: image_x_o, iy: image_y_o, iw: image_w_o, st: status_o});
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog > WDOG_MAX) timed_out <= 1'b1;
    end
  end

  // Write one register; drop cfg_we_i and settle before returning so back-to-back writes never collide.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Send one scene point; hold it until accepted.
  task automatic send_point(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    scene_x_i <= sx;
    scene_y_i <= sy;
    scene_z_i <= sz;
    do @(posedge clk_i); while (in_stall_o);
    board.note_point(sx, sy, sz);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
      2: return 32'($signed($urandom_range(2 << FB)) - (1 << FB));
      default: return 32'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'd0;
      default: return 32'($signed($urandom_range(6 << FB)) - (3 << FB));
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n && !timed_out; i++)
      send_point(rand_coord(), rand_coord(), rand_depth());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero depth, small radius, huge quotient.
    send_point(32'h0, 32'h0, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0000_0100, 32'hffff_ff00, 32'h0001_0000);
    send_point(32'h0000_028f, 32'h0, 32'h0001_0000);
    send_point(32'h0000_0290, 32'h0, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'hfffe_0000, 32'h0003_0000, 32'hffff_0000);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0);
    drain();

    random_phase(250, 0, 0);

    write_reg(CFG_FOCAL_X, 32'h7fff_ffff);
    write_reg(CFG_FOCAL_Y, 32'h8000_0000);
    write_reg(CFG_CENTRE_X, 32'h7fff_0000);
    write_reg(CFG_CENTRE_Y, 32'h8000_0000);
    write_reg(CFG_HOMOG, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    random_phase(200, 82, 0);

    write_reg(CFG_FOCAL_X, 32'h0100_0000);
    write_reg(CFG_FOCAL_Y, 32'hfe00_0000);
    write_reg(CFG_CENTRE_X, 32'h0140_0000);
    write_reg(CFG_CENTRE_Y, 32'h00f0_0000);
    write_reg(CFG_HOMOG, 32'h7fff_ffff);
    random_phase(250, 0, 82);

    for (int k = 0; k < 5; k++)
      write_reg(CFG_IDX_W'(k), $urandom());
    random_phase(250, 22, 22);

    if (!timed_out && board.errors == 0 && board.pending.size() == 0)
      $display("** equidistant_point_projection: PASSED **");
    else
      $display("** equidistant_point_projection: FAILED **");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("%0t: timeout, no transaction for %0d cycles", $time, WDOG_MAX);
    $display("** equidistant_point_projection: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
src/epp_pkg.sv
src/epp_div.sv
src/epp_isqrt.sv
src/epp_cordic.sv
src/equidistant_point_projection.sv
tb/tb_equidistant_point_projection.sv
